@@ hdl/ncu_pkg.sv @@
// ----------------------------------------------------------------------------
// ncu_pkg
// types and constants shared by the nearest-center competitive update block
// ----------------------------------------------------------------------------
package ncu_pkg;

  localparam int COORD_W = 16;
  localparam int RATE_W  = 16;
  localparam int DIST_W  = 33;
  localparam int SLOT_W  = 3;
  localparam int OP_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_TRAIN = 2'd1;
  localparam logic [OP_W-1:0] OP_EPOCH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_DECAY   = 2'd1;

  localparam logic [RATE_W-1:0] RATE_RESET  = 16'd32768;
  localparam logic [RATE_W-1:0] DECAY_RESET = 16'd62259;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic [SLOT_W-1:0]         center_slot;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] winner_index;
    logic [DIST_W-1:0] winner_distance_sq;
    logic              epoch_moved;
    logic [RATE_W-1:0] current_rate;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic scan_rd;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } dp_status_t;

endpackage

@@ hdl/nearest_center_competitive_update.sv @@
// ----------------------------------------------------------------------------
// nearest_center_competitive_update
// winner-take-all vector quantizer for 2-d points in signed q8.8
// ----------------------------------------------------------------------------
// One word is handled at a time and every word gives one result word. A load
// or an unused operation goes from acceptance straight to the write-back
// state, an end-of-epoch word first passes the step state (for the 16x16
// rate decay multiply), and a train word passes the scan, drain, step and
// write-back states: the centers sit in a memory with one read port, scanned
// one center per cycle into a distance pipeline two stages deep, followed by
// the step multiply and the write-back. A new word is accepted while the
// previous result still waits on the output; only the write-back state
// waits for the output register to free up. Configuration writes are always
// taken and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module nearest_center_competitive_update #(
  parameter int NUM_CENTERS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ncu_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ncu_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ncu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ncu_pkg::RATE_W-1:0]    cfg_data
);

  ncu_pkg::dp_cmd_t    cmd;
  ncu_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  ncu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ncu_datapath #(
    .NUM_CENTERS (NUM_CENTERS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  a_result_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result word appeared without an item in progress");

  a_epoch_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.epoch_moved |->
      (out_data.winner_index == '0) && (out_data.winner_distance_sq == '0))
    else $error("epoch result carries winner fields");
`endif

endmodule

@@ hdl/ncu_ctrl.sv @@
// ----------------------------------------------------------------------------
// ncu_ctrl
// sequencer: accepts one word, runs the center scan and update step where the operation needs them, then finish
// ----------------------------------------------------------------------------
module ncu_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [ncu_pkg::OP_W-1:0]  in_op,
  output logic                      in_ready,
  input  ncu_pkg::dp_status_t       status,
  output ncu_pkg::dp_cmd_t          cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DRAIN1 = 6'b000100,
    S_DRAIN2 = 6'b001000,
    S_STEP   = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == ncu_pkg::OP_TRAIN) begin
            state_nxt = S_SCAN;
          end else if (in_op == ncu_pkg::OP_EPOCH) begin
            state_nxt = S_STEP;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        if (status.scan_last) begin
          state_nxt = S_DRAIN1;
        end
      end
      S_DRAIN1: state_nxt = S_DRAIN2;
      S_DRAIN2: state_nxt = S_STEP;
      S_STEP:   state_nxt = S_FINISH;
      S_FINISH: begin
        if (!status.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready    = (state_r == S_IDLE);
  assign cmd.capture = (state_r == S_IDLE) && in_valid;
  assign cmd.scan_rd = (state_r == S_SCAN);
  assign cmd.step    = (state_r == S_STEP);
  assign cmd.finish  = (state_r == S_FINISH) && !status.out_busy;

endmodule

@@ hdl/ncu_datapath.sv @@
// ----------------------------------------------------------------------------
// ncu_datapath
// center memory, distance pipeline, best-center tracking, update and output
// ----------------------------------------------------------------------------
module ncu_datapath #(
  parameter int NUM_CENTERS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ncu_pkg::in_item_t              in_data,
  input  logic                           cfg_valid,
  input  logic [ncu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ncu_pkg::RATE_W-1:0]     cfg_data,
  input  ncu_pkg::dp_cmd_t               cmd,
  output ncu_pkg::dp_status_t            status,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ncu_pkg::out_item_t             out_data
);

  localparam int IW = (NUM_CENTERS > 1) ? $clog2(NUM_CENTERS) : 1;

  logic signed [15:0] mem_x [NUM_CENTERS];
  logic signed [15:0] mem_y [NUM_CENTERS];

  ncu_pkg::in_item_t  item_r;
  logic [IW-1:0]      addr_r;

  logic               v1_r;
  logic [IW-1:0]      i1_r;
  logic signed [15:0] rd_x_r;
  logic signed [15:0] rd_y_r;

  logic               v2_r;
  logic [IW-1:0]      i2_r;
  logic signed [15:0] x2_r;
  logic signed [15:0] y2_r;
  logic [31:0]        sqx_r;
  logic [31:0]        sqy_r;

  logic [IW-1:0]      best_i_r;
  logic [32:0]        best_d_r;
  logic signed [15:0] best_x_r;
  logic signed [15:0] best_y_r;

  logic signed [33:0] stepx_r;
  logic signed [33:0] stepy_r;
  logic [31:0]        dec_prod_r;

  logic [15:0]        rate_r;
  logic [15:0]        decay_r;
  logic               moved_r;

  logic               out_valid_r;
  ncu_pkg::out_item_t out_data_r;
  ncu_pkg::out_item_t out_data_nxt;

  logic signed [16:0] dx1;
  logic signed [16:0] dy1;
  logic signed [33:0] sqx_full;
  logic signed [33:0] sqy_full;
  logic [32:0]        dist2;
  logic signed [16:0] dxs;
  logic signed [16:0] dys;
  logic signed [15:0] new_x;
  logic signed [15:0] new_y;
  logic               slot_ok;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic signed [15:0] wr_x;
  logic signed [15:0] wr_y;

  // item capture and scan address
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
    end else if (cmd.capture) begin
      addr_r <= '0;
    end else if (cmd.scan_rd) begin
      addr_r <= IW'(addr_r + 1'b1);
    end
  end

  assign status.scan_last = (addr_r == IW'(NUM_CENTERS - 1));
  assign status.out_busy  = out_valid_r && !out_ready;

  // center memory
  always_comb begin
    slot_ok = (32'(item_r.center_slot) < NUM_CENTERS);
    new_x   = 16'(best_x_r + stepx_r[31:16]);
    new_y   = 16'(best_y_r + stepy_r[31:16]);
    wr_en   = 1'b0;
    wr_addr = best_i_r;
    wr_x    = new_x;
    wr_y    = new_y;
    if (item_r.operation == ncu_pkg::OP_LOAD) begin
      wr_en   = slot_ok;
      wr_addr = IW'(item_r.center_slot);
      wr_x    = item_r.x_coord;
      wr_y    = item_r.y_coord;
    end else if (item_r.operation == ncu_pkg::OP_TRAIN) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && wr_en) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      rd_x_r <= mem_x[addr_r];
      rd_y_r <= mem_y[addr_r];
      i1_r   <= addr_r;
    end
  end

  // distance pipeline
  always_comb begin
    dx1      = 17'(item_r.x_coord) - 17'(rd_x_r);
    dy1      = 17'(item_r.y_coord) - 17'(rd_y_r);
    sqx_full = 34'(dx1) * 34'(dx1);
    sqy_full = 34'(dy1) * 34'(dy1);
    dist2    = 33'(sqx_r) + 33'(sqy_r);
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      sqx_r <= sqx_full[31:0];
      sqy_r <= sqy_full[31:0];
      x2_r  <= rd_x_r;
      y2_r  <= rd_y_r;
      i2_r  <= i1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.scan_rd;
      v2_r <= v1_r;
    end
  end

  // lowest index wins on ties
  always_ff @(posedge clk) begin
    if (v2_r && ((i2_r == '0) || (dist2 < best_d_r))) begin
      best_d_r <= dist2;
      best_i_r <= i2_r;
      best_x_r <= x2_r;
      best_y_r <= y2_r;
    end
  end

  // update step products
  always_comb begin
    dxs = 17'(item_r.x_coord) - 17'(best_x_r);
    dys = 17'(item_r.y_coord) - 17'(best_y_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      stepx_r    <= 34'($signed({1'b0, rate_r})) * 34'(dxs);
      stepy_r    <= 34'($signed({1'b0, rate_r})) * 34'(dys);
      dec_prod_r <= 32'(rate_r) * 32'(decay_r);
    end
  end

  // rate, decay and moved flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= ncu_pkg::RATE_RESET;
      decay_r <= ncu_pkg::DECAY_RESET;
      moved_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          ncu_pkg::REG_INITIAL_RATE: rate_r  <= cfg_data;
          ncu_pkg::REG_RATE_DECAY:   decay_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.finish) begin
        if (item_r.operation == ncu_pkg::OP_TRAIN) begin
          if ((new_x != best_x_r) || (new_y != best_y_r)) begin
            moved_r <= 1'b1;
          end
        end else if (item_r.operation == ncu_pkg::OP_EPOCH) begin
          moved_r <= 1'b0;
          rate_r  <= dec_prod_r[31:16];
        end
      end
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    out_data_nxt              = '0;
    out_data_nxt.current_rate = rate_r;
    unique case (item_r.operation)
      ncu_pkg::OP_TRAIN: begin
        out_data_nxt.winner_index       = ncu_pkg::SLOT_W'(best_i_r);
        out_data_nxt.winner_distance_sq = best_d_r;
      end
      ncu_pkg::OP_EPOCH: begin
        out_data_nxt.epoch_moved  = moved_r;
        out_data_nxt.current_rate = dec_prod_r[31:16];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
